@@ hw/rtl/qyaw_pkg.sv @@
package qyaw_pkg;

  // Q2.30 matrix terms need 34 bits; one spare bit.
  localparam int TW = 35;
  // CORDIC datapath: terms scaled by 2^16 plus gain and pre-rotation growth.
  localparam int CW = 53;
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [TW-1:0] ONE_Q30 = TW'(1 << 30);
  localparam logic signed [TW-1:0] NEG_ONE_Q30 = -ONE_Q30;
  localparam logic [31:0] ANG_P90 = 32'h4000_0000;
  localparam logic [31:0] ANG_M90 = 32'hC000_0000;
  localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

  // atan(2^-i), 2^32 = 2 pi, rounded to nearest
  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_in_t;

  typedef struct packed {
    logic signed [15:0] heading;
    logic               gimbal_lock;
  } yaw_out_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          ang;
    logic                 gimbal;
    logic                 zero;
  } cordic_t;

endpackage

@@ hw/rtl/qyaw_terms.sv @@
module qyaw_terms import qyaw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  quat_in_t data_i,
  output logic     valid_o,
  output cordic_t  data_o
);

  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] yy_q, zz_q, xy_q, wz_q, wy_q, xz_q;
  logic               v1_q, v2_q;

  logic signed [TW-1:0] m00, m10, s;
  logic signed [CW-1:0] xs, ys;
  cordic_t              pre_d, pre_q;

  assign qw = data_i.quat_w;
  assign qx = data_i.quat_x;
  assign qy = data_i.quat_y;
  assign qz = data_i.quat_z;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yy_q <= qy * qy;
      zz_q <= qz * qz;
      xy_q <= qx * qy;
      wz_q <= qw * qz;
      wy_q <= qw * qy;
      xz_q <= qx * qz;
    end
  end

  always_comb begin
    m00 = ONE_Q30 - (TW'(yy_q) <<< 1) - (TW'(zz_q) <<< 1);
    m10 = (TW'(xy_q) + TW'(wz_q)) <<< 1;
    s   = (TW'(wy_q) - TW'(xz_q)) <<< 1;
    xs  = CW'(m00) <<< 16;
    ys  = CW'(m10) <<< 16;

    pre_d.gimbal = (s == ONE_Q30) || (s == NEG_ONE_Q30);
    pre_d.zero   = (m00 == '0) && (m10 == '0);
    pre_d.x      = xs;
    pre_d.y      = ys;
    pre_d.ang    = '0;
    if (xs[CW-1]) begin
      if (!ys[CW-1]) begin
        pre_d.x   = ys;
        pre_d.y   = -xs;
        pre_d.ang = ANG_P90;
      end else begin
        pre_d.x   = -ys;
        pre_d.y   = xs;
        pre_d.ang = ANG_M90;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q <= pre_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = pre_q;

endmodule

@@ hw/rtl/qyaw_cell.sv @@
module qyaw_cell import qyaw_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  cordic_t data_i,
  output logic    valid_o,
  output cordic_t data_o
);

  logic signed [CW-1:0] xi, yi, dx, dy;
  cordic_t              cell_d, cell_q;
  logic                 valid_q;

  assign xi = data_i.x;
  assign yi = data_i.y;
  assign dx = yi >>> STAGE;
  assign dy = xi >>> STAGE;

  always_comb begin
    cell_d = data_i;
    if (!yi[CW-1]) begin
      cell_d.x   = xi + dx;
      cell_d.y   = yi - dy;
      cell_d.ang = data_i.ang + ATAN_TAB[STAGE];
    end else begin
      cell_d.x   = xi - dx;
      cell_d.y   = yi + dy;
      cell_d.ang = data_i.ang - ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = cell_q;

endmodule

@@ hw/rtl/quaternion_to_yaw_top.sv @@
// Quaternion to heading. Takes a Q1.15 quaternion (w,x,y,z) per transaction and returns the
// yaw as a 16-bit binary angle (32768 = pi) plus a gimbal-lock flag (heading forced to zero
// when the pitch sine is exactly +1 or -1). One transaction is taken every clock while
// in_ready_o is high; stages: one multiplier stage, one stage forming the matrix terms and
// the quadrant pre-rotation, one CORDIC cell per micro-rotation, and the output register. An
// output register with a skid entry decouples the sides; in_ready_o is a register output and
// drops only while the skid entry is occupied.
module quaternion_to_yaw_top import qyaw_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  quat_in_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output yaw_out_t out_data_o
);

  localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  logic     en;
  logic     chain_v [NSTEPS+1];
  cordic_t  chain_d [NSTEPS+1];
  logic     [31:0] ang_rnd;
  yaw_out_t res;
  yaw_out_t out_q, sk_q;
  logic     out_v_q, sk_v_q;

  assign en = !sk_v_q;

  qyaw_terms u_terms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (chain_v[0]),
    .data_o  (chain_d[0])
  );

  for (genvar g = 0; g < NSTEPS; g++) begin : g_cell
    qyaw_cell #(.STAGE(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[g]),
      .data_i  (chain_d[g]),
      .valid_o (chain_v[g+1]),
      .data_o  (chain_d[g+1])
    );
  end

  always_comb begin
    ang_rnd         = chain_d[NSTEPS].ang + ROUND_HALF;
    res.gimbal_lock = chain_d[NSTEPS].gimbal;
    if (chain_d[NSTEPS].gimbal || chain_d[NSTEPS].zero) begin
      res.heading = '0;
    end else begin
      res.heading = ang_rnd[31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (out_ready_i) begin
        out_q <= sk_q;
      end
    end else if (!out_v_q || out_ready_i) begin
      out_q <= res;
    end else begin
      sk_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (sk_v_q) begin
      if (out_ready_i) begin
        sk_v_q <= 1'b0;
      end
    end else if (!out_v_q || out_ready_i) begin
      out_v_q <= chain_v[NSTEPS];
    end else if (chain_v[NSTEPS]) begin
      sk_v_q <= 1'b1;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> out_v_q)
    else $error("skid entry held without a pending output");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_v_q) |-> $past(out_v_q && !out_ready_i && chain_v[NSTEPS]))
    else $error("skid entry filled while output was free");

  a_gimbal_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.gimbal_lock) |-> (out_data_o.heading == '0))
    else $error("nonzero heading under gimbal lock");
`endif

endmodule

@@ tb/sv/tb_quaternion_to_yaw_top.sv @@
`timescale 1ns / 100ps

module tb_quaternion_to_yaw_top;
  import qyaw_pkg::*;

  localparam int STEPS = 16;
  localparam int N_RANDOM = 800;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint Q30 = longint'(1) <<< 30;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  quat_in_t in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  yaw_out_t out_data_o;

  class yaw_scoreboard;
    yaw_out_t heading_q[$];
    int       mismatches = 0;
    int       checked = 0;
    int       locks = 0;

    function yaw_out_t predict_heading(quat_in_t q);
      longint w, x, y, z, m00, m10, s, vx, vy, tmp, dx, dy;
      logic [31:0] ang;
      yaw_out_t r;
      w = longint'(q.quat_w);
      x = longint'(q.quat_x);
      y = longint'(q.quat_y);
      z = longint'(q.quat_z);
      m00 = Q30 - 2 * y * y - 2 * z * z;
      m10 = 2 * x * y + 2 * w * z;
      s = 2 * w * y - 2 * x * z;
      r = '0;
      if (s == Q30 || s == -Q30) begin
        r.gimbal_lock = 1'b1;
      end else if (m00 != 0 || m10 != 0) begin
        vx = m00 * 65536;
        vy = m10 * 65536;
        ang = '0;
        if (vx < 0) begin
          tmp = vx;
          if (vy >= 0) begin
            vx = vy;
            vy = -tmp;
            ang = ANG_P90;
          end else begin
            vx = -vy;
            vy = tmp;
            ang = ANG_M90;
          end
        end
        for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
          dx = vy >>> i;
          dy = vx >>> i;
          if (vy >= 0) begin
            vx += dx;
            vy -= dy;
            ang += ATAN_TAB[i];
          end else begin
            vx -= dx;
            vy += dy;
            ang -= ATAN_TAB[i];
          end
        end
        ang = ang + ROUND_HALF;
        r.heading = ang[31:16];
      end
      return r;
    endfunction

    function void note_quat(quat_in_t q);
      heading_q = {heading_q, predict_heading(q)};
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    function void check_yaw(yaw_out_t got);
      yaw_out_t want;
      if (heading_q.size() == 0) begin
        report($sformatf("unexpected transaction heading=%0d lock=%0b",
                         got.heading, got.gimbal_lock));
        return;
      end
      want = heading_q.pop_front();
      checked++;
      if (want.gimbal_lock) locks++;
      if (got.heading !== want.heading)
        report($sformatf("heading: expected %0d actual %0d", want.heading, got.heading));
      if (got.gimbal_lock !== want.gimbal_lock)
        report($sformatf("gimbal_lock: expected %0b actual %0b",
                         want.gimbal_lock, got.gimbal_lock));
    endfunction
  endclass

  yaw_scoreboard sb = new();
  int burst_left = 0;
  int cycles = 0;
  int rx_mode = 0;
  int rx_stall = 0;
  int sent = 0;

  quaternion_to_yaw_top #(
    .CORDIC_STEPS(STEPS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: always ready, random stalls, or long stall stretches
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_yaw(out_data_o);
    if (cycles % 150 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 9) < 7);
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          out_ready_i <= 1'b0;
        end else begin
          if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 12);
          out_ready_i <= 1'b1;
        end
      end
    endcase
  end

  function automatic quat_in_t mk_quat(int w, int x, int y, int z);
    quat_in_t q;
    q.quat_w = 16'(w);
    q.quat_x = 16'(x);
    q.quat_y = 16'(y);
    q.quat_z = 16'(z);
    return q;
  endfunction

  function automatic quat_in_t unit_quat();
    real c[4];
    real n;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = real'($signed($urandom_range(0, 65535)) - 32768);
      n += c[i] * c[i];
    end
    if (n < 1.0) return mk_quat(32767, 0, 0, 0);
    n = 32767.0 / $sqrt(n);
    return mk_quat(int'(c[0] * n), int'(c[1] * n), int'(c[2] * n), int'(c[3] * n));
  endfunction

  function automatic int edge_value();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      4: return 32767;
      5: return 16384;
      default: return -16384;
    endcase
  endfunction

  // product of the pair is exactly +/-2^29, so s lands on +/-1
  function automatic quat_in_t lock_quat();
    int a, b, r;
    case ($urandom_range(0, 3))
      0: begin a = 16384;  b = -32768; end
      1: begin a = -16384; b = -32768; end
      2: begin a = -32768; b = 16384;  end
      default: begin a = -32768; b = -16384; end
    endcase
    r = $signed($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 1)) return mk_quat(a, 0, b, r);
    return mk_quat(0, a, r, b);
  endfunction

  task automatic drive_quat(input quat_in_t q);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i <= q;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_quat(q);
    burst_left--;
    sent++;
  endtask

  initial begin
    quat_in_t directed[$];
    int pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = {directed, mk_quat(32767, 0, 0, 0)};
    directed = {directed, mk_quat(0, 0, 0, 0)};
    directed = {directed, mk_quat(-32768, -32768, -32768, -32768)};
    directed = {directed, mk_quat(32767, 32767, 32767, 32767)};
    directed = {directed, mk_quat(0, -32768, 0, 16384)};
    directed = {directed, mk_quat(-32768, 0, 16384, 0)};
    directed = {directed, mk_quat(-16384, 0, -32768, 1234)};
    directed = {directed, mk_quat(0, 0, 16384, 16384)};
    directed = {directed, mk_quat(0, 0, 0, 32767)};
    directed = {directed, mk_quat(0, 0, 0, -32768)};
    directed = {directed, mk_quat(23170, 0, 0, 23170)};
    directed = {directed, mk_quat(23170, 0, 0, -23170)};
    directed = {directed, mk_quat(-23170, 0, 0, 23170)};
    directed = {directed, mk_quat(16384, 16384, 16384, 16384)};
    directed = {directed, mk_quat(23170, 23170, 0, 0)};
    directed = {directed, mk_quat(23170, 0, 23170, 0)};
    directed = {directed, mk_quat(1, -1, 1, -1)};
    directed = {directed, mk_quat(-1, 1, -1, 1)};
    directed = {directed, mk_quat(12540, 0, 0, 30273)};
    directed = {directed, mk_quat(12540, 0, 0, -30273)};
    directed = {directed, mk_quat(32767, -32768, 32767, -32768)};
    directed = {directed, mk_quat(0, 32767, -32768, 0)};
    foreach (directed[i]) drive_quat(directed[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)
        drive_quat(unit_quat());
      else if (pick < 85)
        drive_quat(quat_in_t'({$urandom(), $urandom()}));
      else if (pick < 93)
        drive_quat(lock_quat());
      else
        drive_quat(mk_quat(edge_value(), edge_value(), edge_value(), edge_value()));
    end
    in_valid_i <= 1'b0;

    while (sb.heading_q.size() > 0) @(posedge clk_i);
    repeat (STEPS + 10) @(posedge clk_i);

    $display("sent %0d quaternions, checked %0d headings, %0d of them in gimbal lock",
             sent, sb.checked, sb.locks);
    $display("mismatches %0d, outstanding %0d", sb.mismatches, sb.heading_q.size());
    if (sb.mismatches == 0 && sb.heading_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
